// ===== src/bbe_pkg.sv =====
// Package for the edge-normalized box blur: sizes, register codes, FSM
// states and the divider request and response types. No dependencies.
`timescale 1ns / 1ps
package bbe_pkg;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int MAX_RADIUS = 6;
  localparam int LINE_DEPTH = (2 * MAX_RADIUS + 1) * MAX_WIDTH + 2 * MAX_RADIUS + 1;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int SUM_W      = 16;
  localparam int CNT_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DAT_W  = 13;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 2'd2;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EVAL, ST_READ, ST_FLUSH, ST_START, ST_DIV, ST_DONE
  } state_t;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] sum_a;
    logic [SUM_W-1:0] sum_r;
    logic [SUM_W-1:0] sum_g;
    logic [SUM_W-1:0] sum_b;
    logic [CNT_W-1:0] cnt;
  } div_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] q_a;
    logic [7:0] q_r;
    logic [7:0] q_g;
    logic [7:0] q_b;
  } div_resp_t;
endpackage

// ===== src/bbe_pix_if.sv =====
// Input pixel channel: valid/ready handshake with op and ARGB payload.
// Depends on nothing.
`timescale 1ns / 1ps
interface bbe_pix_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] in_alpha;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  modport source (output valid, op, in_alpha, in_red, in_green, in_blue, input ready);
  modport sink   (input valid, op, in_alpha, in_red, in_green, in_blue, output ready);
endinterface

// ===== src/bbe_res_if.sv =====
// Result channel: valid/ready handshake with blurred ARGB and frame end.
// Depends on nothing.
`timescale 1ns / 1ps
interface bbe_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] blur_alpha;
  logic [7:0] blur_red;
  logic [7:0] blur_green;
  logic [7:0] blur_blue;
  logic       end_of_frame;
  modport source (output valid, blur_alpha, blur_red, blur_green, blur_blue, end_of_frame,
                  input ready);
  modport sink   (input valid, blur_alpha, blur_red, blur_green, blur_blue, end_of_frame,
                  output ready);
endinterface

// ===== src/bbe_cfg_if.sv =====
// Configuration write channel: valid/ready with register index and data.
// Depends on bbe_pkg for the field widths.
`timescale 1ns / 1ps
interface bbe_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bbe_pkg::CFG_IDX_W-1:0] index;
  logic [bbe_pkg::CFG_DAT_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/box_blur_edge_normalized_core.sv =====
// Top level of the edge-normalized box blur: control FSM, window walker,
// accumulators and output register. Depends on bbe_pkg, the interfaces,
// bbe_line_store and bbe_divider.
//
// Usage: pixels enter on pix in raster order (op = pixel); op = drain
// beats flush results pending once the whole frame has arrived. Results
// leave on res in raster order, end_of_frame marking the last of a frame.
// Registers (width, height, radius) are written on cfg while idle; any
// write to one of them restarts the frame.
// A beat that yields no result passes through the evaluation state, and a
// pixel dropped after the frame is complete skips it. One that yields a result
// walks the (2r+1)^2 window through the single line-store read port, one entry
// per cycle, then runs a 16-step bit-serial divide.
// The output register holds a result until res.ready; the next input beat
// is taken meanwhile, and only its own result waits for the register.
// Reset restores the default registers and clears the input and output
// position counters; the line store is not cleared, as only entries written
// in the current frame are read.
`timescale 1ns / 1ps
module box_blur_edge_normalized_core (
  input  logic         clk,
  input  logic         rst,
  bbe_pix_if.sink      pix,
  bbe_res_if.source    res,
  bbe_cfg_if.sink      cfg
);
  localparam int AW = bbe_pkg::ADDR_W;
  localparam logic [AW-1:0] DEPTH = AW'(bbe_pkg::LINE_DEPTH);

  logic [10:0] cfg_w;
  logic [12:0] cfg_h;
  logic [2:0]  cfg_r;
  logic [10:0] w;
  logic [12:0] h;
  logic [2:0]  r;
  logic [22:0] total;
  logic [12:0] lag;

  bbe_pkg::state_t state, state_next;

  logic [22:0]   rcv;
  logic          fc;
  logic [AW-1:0] wptr;
  logic [10:0]   ocol;
  logic [12:0]   orow;
  logic [22:0]   oidx;
  logic [AW-1:0] optr;

  logic signed [14:0] yy;
  logic signed [11:0] xx;
  logic [3:0]    dyc;
  logic [3:0]    dxc;
  logic [AW-1:0] raddr;
  logic          rd_vld;
  logic          rd_inb;
  logic [31:0]   rdata;

  logic [bbe_pkg::SUM_W-1:0] acc_a, acc_r, acc_g, acc_b;
  logic [bbe_pkg::CNT_W-1:0] acc_cnt;

  bbe_pkg::div_req_t  dreq;
  bbe_pkg::div_resp_t dresp;

  logic [7:0] q_a, q_r, q_g, q_b;
  logic       out_load;
  logic       accept;
  logic       cfg_wr;
  logic       restart;
  logic       inb;
  logic       walk_end;
  logic       last;
  logic       div_start;
  logic [23:0] need;
  logic [3:0]  two_r;

  // Effective register values after clamping.
  always_comb begin
    w = (cfg_w == '0) ? 11'd1 : (cfg_w > 11'(bbe_pkg::MAX_WIDTH)) ?
        11'(bbe_pkg::MAX_WIDTH) : cfg_w;
    h = (cfg_h == '0) ? 13'd1 : (cfg_h > 13'(bbe_pkg::MAX_HEIGHT)) ?
        13'(bbe_pkg::MAX_HEIGHT) : cfg_h;
    r = (cfg_r == '0) ? 3'd1 : (cfg_r > 3'(bbe_pkg::MAX_RADIUS)) ?
        3'(bbe_pkg::MAX_RADIUS) : cfg_r;
  end

  assign two_r = {r, 1'b0};

  // Frame size and lag are registered and follow the registers in the next cycle;
  // the user must change them only while idle, which the block does not enforce.
  always_ff @(posedge clk) begin
    total <= 23'(w) * 23'(h);
    lag   <= 13'(r) * 13'(w) + 13'(r);
  end

  assign cfg.ready = 1'b1;
  assign cfg_wr = cfg.valid && (cfg.index == bbe_pkg::REG_WIDTH ||
                                cfg.index == bbe_pkg::REG_HEIGHT ||
                                cfg.index == bbe_pkg::REG_RADIUS);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_w <= 11'd1024;
      cfg_h <= 13'd1024;
      cfg_r <= 3'd1;
    end else if (cfg.valid) begin
      case (cfg.index)
        bbe_pkg::REG_WIDTH:  cfg_w <= cfg.data[10:0];
        bbe_pkg::REG_HEIGHT: cfg_h <= cfg.data;
        bbe_pkg::REG_RADIUS: cfg_r <= cfg.data[2:0];
        default: ;
      endcase
    end
  end

  assign pix.ready = (state == bbe_pkg::ST_IDLE);
  assign accept    = pix.valid && pix.ready;
  assign need      = ({1'b0, oidx} + 24'(lag) + 24'd1 > {1'b0, total}) ?
                     {1'b0, total} : {1'b0, oidx} + 24'(lag) + 24'd1;
  assign inb       = (yy >= 0) && (yy < $signed({2'b00, h})) &&
                     (xx >= 0) && (xx < $signed({1'b0, w}));
  assign walk_end  = (dyc == two_r) && (dxc == two_r);
  assign last      = (oidx + 23'd1 >= total);
  assign out_load  = (state == bbe_pkg::ST_DONE) && (!res.valid || res.ready);
  assign restart   = cfg_wr || (out_load && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bbe_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // A pixel that arrives after the frame is complete is dropped and yields
  // nothing, so it skips the evaluation.
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    case (state)
      bbe_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = (pix.op == bbe_pkg::OP_PIXEL && fc) ? bbe_pkg::ST_IDLE :
                       bbe_pkg::ST_EVAL;
        end
      end
      bbe_pkg::ST_EVAL:  state_next = ({1'b0, rcv} >= need) ? bbe_pkg::ST_READ :
                                      bbe_pkg::ST_IDLE;
      bbe_pkg::ST_READ:  if (walk_end) state_next = bbe_pkg::ST_FLUSH;
      bbe_pkg::ST_FLUSH: state_next = bbe_pkg::ST_START;
      bbe_pkg::ST_START: begin
        div_start  = 1'b1;
        state_next = bbe_pkg::ST_DIV;
      end
      bbe_pkg::ST_DIV:   if (dresp.done) state_next = bbe_pkg::ST_DONE;
      bbe_pkg::ST_DONE:  if (out_load) state_next = bbe_pkg::ST_IDLE;
      default:           state_next = bbe_pkg::ST_IDLE;
    endcase
  end

  // Input side: write pointer tracks the frame pixel index modulo the depth.
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      rcv  <= '0;
      fc   <= 1'b0;
      wptr <= '0;
    end else if (accept && pix.op == bbe_pkg::OP_PIXEL && !fc) begin
      rcv  <= rcv + 23'd1;
      fc   <= (rcv + 23'd1 == total);
      wptr <= (wptr == DEPTH - 1'b1) ? '0 : wptr + 1'b1;
    end
  end

  // Output position and its line-store address.
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      ocol <= '0;
      orow <= '0;
      oidx <= '0;
      optr <= '0;
    end else if (out_load) begin
      oidx <= oidx + 23'd1;
      optr <= (optr == DEPTH - 1'b1) ? '0 : optr + 1'b1;
      if (ocol + 11'd1 >= w) begin
        ocol <= '0;
        orow <= orow + 13'd1;
      end else begin
        ocol <= ocol + 11'd1;
      end
    end
  end

  // Window walker: one line-store read per cycle, row by row.
  always_ff @(posedge clk) begin
    logic [AW:0] s1;
    logic [AW:0] s2;
    if (state == bbe_pkg::ST_EVAL) begin
      yy  <= $signed({2'b00, orow}) - $signed({12'd0, r});
      xx  <= $signed({1'b0, ocol}) - $signed({9'd0, r});
      dyc <= '0;
      dxc <= '0;
      raddr <= ({1'b0, optr} >= (AW+1)'(lag)) ? AW'({1'b0, optr} - (AW+1)'(lag)) :
               AW'({1'b0, optr} + (AW+1)'(DEPTH) - (AW+1)'(lag));
    end else if (state == bbe_pkg::ST_READ) begin
      if (dxc == two_r) begin
        dxc <= '0;
        dyc <= dyc + 4'd1;
        yy  <= yy + 15'sd1;
        xx  <= $signed({1'b0, ocol}) - $signed({9'd0, r});
        s1 = {1'b0, raddr} + (AW+1)'(w);
        if (s1 >= (AW+1)'(DEPTH)) s1 = s1 - (AW+1)'(DEPTH);
        if (s1 >= (AW+1)'(two_r)) begin
          s2 = s1 - (AW+1)'(two_r);
        end else begin
          s2 = s1 + (AW+1)'(DEPTH) - (AW+1)'(two_r);
        end
        raddr <= AW'(s2);
      end else begin
        dxc <= dxc + 4'd1;
        xx  <= xx + 12'sd1;
        raddr <= (raddr == DEPTH - 1'b1) ? '0 : raddr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
      rd_inb <= 1'b0;
    end else begin
      rd_vld <= (state == bbe_pkg::ST_READ);
      rd_inb <= inb;
    end
  end

  always_ff @(posedge clk) begin
    if (state == bbe_pkg::ST_EVAL) begin
      acc_a   <= '0;
      acc_r   <= '0;
      acc_g   <= '0;
      acc_b   <= '0;
      acc_cnt <= '0;
    end else if (rd_vld && rd_inb) begin
      acc_a   <= acc_a + {8'd0, rdata[31:24]};
      acc_r   <= acc_r + {8'd0, rdata[23:16]};
      acc_g   <= acc_g + {8'd0, rdata[15:8]};
      acc_b   <= acc_b + {8'd0, rdata[7:0]};
      acc_cnt <= acc_cnt + 8'd1;
    end
  end

  bbe_line_store u_store (
    .clk   (clk),
    .we    (accept && pix.op == bbe_pkg::OP_PIXEL && !fc),
    .waddr (wptr),
    .wdata ({pix.in_alpha, pix.in_red, pix.in_green, pix.in_blue}),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign dreq.start = div_start;
  assign dreq.sum_a = acc_a;
  assign dreq.sum_r = acc_r;
  assign dreq.sum_g = acc_g;
  assign dreq.sum_b = acc_b;
  assign dreq.cnt   = acc_cnt;

  bbe_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (dreq),
    .resp (dresp)
  );

  always_ff @(posedge clk) begin
    if (dresp.done) begin
      q_a <= dresp.q_a;
      q_r <= dresp.q_r;
      q_g <= dresp.q_g;
      q_b <= dresp.q_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (out_load) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res.blur_alpha   <= q_a;
      res.blur_red     <= q_r;
      res.blur_green   <= q_g;
      res.blur_blue    <= q_b;
      res.end_of_frame <= last;
    end
  end

  // The walker must never address past the end of the store.
  a_raddr_range: assert property (@(posedge clk) disable iff (rst)
    (state == bbe_pkg::ST_READ) |-> (raddr < DEPTH))
    else $error("line store read address out of range");

  // The window always holds its center pixel, so the divisor is nonzero.
  a_cnt_nonzero: assert property (@(posedge clk) disable iff (rst)
    dreq.start |-> (acc_cnt != '0))
    else $error("divide started with empty window");

  // A complete frame means every pixel of it was counted.
  a_fc_count: assert property (@(posedge clk) disable iff (rst)
    fc |-> (rcv == total))
    else $error("frame complete without full pixel count");

  // A result is never loaded over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.ready) |-> !out_load)
    else $error("output register overwritten");
endmodule

// ===== src/bbe_line_store.sv =====
// Pixel line store: one write port, one read port, registered read data.
// Depends on bbe_pkg for depth and address width.
`timescale 1ns / 1ps
module bbe_line_store (
  input  logic                        clk,
  input  logic                        we,
  input  logic [bbe_pkg::ADDR_W-1:0]  waddr,
  input  logic [31:0]                 wdata,
  input  logic [bbe_pkg::ADDR_W-1:0]  raddr,
  output logic [31:0]                 rdata
);
  logic [31:0] mem [bbe_pkg::LINE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule

// ===== src/bbe_divider.sv =====
// Four-lane restoring divider, one quotient bit per cycle, shared count.
// Depends on bbe_pkg for the request and response types.
`timescale 1ns / 1ps
module bbe_divider (
  input  logic               clk,
  input  logic               rst,
  input  bbe_pkg::div_req_t  req,
  output bbe_pkg::div_resp_t resp
);
  localparam int BIT_W = $clog2(bbe_pkg::SUM_W + 1);

  logic [bbe_pkg::SUM_W-1:0] dvd [4];
  logic [bbe_pkg::SUM_W-1:0] quo [4];
  logic [bbe_pkg::CNT_W:0]   rem [4];
  logic [bbe_pkg::CNT_W-1:0] dvs;
  logic [BIT_W-1:0]          bits;
  logic                      busy;
  logic                      done;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      bits <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        bits <= BIT_W'(bbe_pkg::SUM_W);
      end else if (busy) begin
        bits <= bits - 1'b1;
        if (bits == BIT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    logic [bbe_pkg::CNT_W+1:0] trial;
    if (req.start) begin
      dvd[0] <= req.sum_a;
      dvd[1] <= req.sum_r;
      dvd[2] <= req.sum_g;
      dvd[3] <= req.sum_b;
      dvs    <= req.cnt;
      for (int i = 0; i < 4; i++) begin
        rem[i] <= '0;
        quo[i] <= '0;
      end
    end else if (busy) begin
      for (int i = 0; i < 4; i++) begin
        trial = {rem[i], dvd[i][bbe_pkg::SUM_W-1]};
        dvd[i] <= {dvd[i][bbe_pkg::SUM_W-2:0], 1'b0};
        if (trial >= {2'b00, dvs}) begin
          rem[i] <= (bbe_pkg::CNT_W+1)'(trial - {2'b00, dvs});
          quo[i] <= {quo[i][bbe_pkg::SUM_W-2:0], 1'b1};
        end else begin
          rem[i] <= (bbe_pkg::CNT_W+1)'(trial);
          quo[i] <= {quo[i][bbe_pkg::SUM_W-2:0], 1'b0};
        end
      end
    end
  end

  assign resp.done = done;
  assign resp.q_a  = quo[0][7:0];
  assign resp.q_r  = quo[1][7:0];
  assign resp.q_g  = quo[2][7:0];
  assign resp.q_b  = quo[3][7:0];
endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the edge-normalized box blur core.
// Depends on bbe_pkg, the bbe_pix_if/bbe_res_if/bbe_cfg_if interfaces and the core.
`timescale 1ns / 1ps
module tb_top;
  localparam logic [bbe_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int DAT_W         = bbe_pkg::CFG_DAT_W;
  localparam int SETTLE_CYCLES = 400;
  localparam int HOLD_CYCLES   = 3000;
  localparam int RANDOM_ITEMS  = 150;

  typedef struct {
    logic       op;
    logic [7:0] a, r, g, b;
  } pix_beat_t;

  typedef struct {
    logic [7:0] a, r, g, b;
    logic       eof;
  } blur_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  bbe_pix_if pix ();
  bbe_res_if res ();
  bbe_cfg_if cfg ();

  box_blur_edge_normalized_core DUT (
    .clk (clk),
    .rst (rst),
    .pix (pix),
    .res (res),
    .cfg (cfg)
  );

  always #5 clk = ~clk;

  pix_beat_t  pixel_q[$];
  blur_beat_t blur_q[$];
  int         err_count;
  int         item_count;
  int         result_count;
  int         phase_count;
  bit         no_idle;
  int         hold_req;
  int         hold_ack;
  int         hold_left;

  // Predictor state.
  logic [10:0] cur_width;
  logic [12:0] cur_height;
  logic [2:0]  cur_radius;
  logic [31:0] win_store [bbe_pkg::LINE_DEPTH];
  int          in_col, in_row, out_col, out_row;
  bit          frame_done;

  function automatic int eff_width();
    if (cur_width < 1) return 1;
    if (cur_width > bbe_pkg::MAX_WIDTH) return bbe_pkg::MAX_WIDTH;
    return cur_width;
  endfunction

  function automatic int eff_height();
    if (cur_height < 1) return 1;
    if (cur_height > bbe_pkg::MAX_HEIGHT) return bbe_pkg::MAX_HEIGHT;
    return cur_height;
  endfunction

  function automatic int eff_radius();
    if (cur_radius < 1) return 1;
    if (cur_radius > bbe_pkg::MAX_RADIUS) return bbe_pkg::MAX_RADIUS;
    return cur_radius;
  endfunction

  task automatic restart_frame();
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
    frame_done = 1'b0;
  endtask

  task automatic emit_mean();
    int w, h, r, total, received, oidx, need, y, x, cnt;
    int sa, sr, sg, sb;
    logic [31:0] p;
    blur_beat_t e;
    w = eff_width();
    h = eff_height();
    r = eff_radius();
    total = w * h;
    received = frame_done ? total : in_row * w + in_col;
    oidx = out_row * w + out_col;
    need = oidx + r * w + r + 1;
    if (need > total) need = total;
    if (received < need) return;
    sa = 0; sr = 0; sg = 0; sb = 0; cnt = 0;
    for (int dy = -r; dy <= r; dy++) begin
      y = out_row + dy;
      if (y < 0 || y >= h) continue;
      for (int dx = -r; dx <= r; dx++) begin
        x = out_col + dx;
        if (x < 0 || x >= w) continue;
        p = win_store[(y * w + x) % bbe_pkg::LINE_DEPTH];
        sa += p[31:24];
        sr += p[23:16];
        sg += p[15:8];
        sb += p[7:0];
        cnt++;
      end
    end
    if (cnt == 0) cnt = 1;
    e.a = 8'(sa / cnt);
    e.r = 8'(sr / cnt);
    e.g = 8'(sg / cnt);
    e.b = 8'(sb / cnt);
    e.eof = (oidx + 1 >= total);
    blur_q.push_back(e);
    if (e.eof) begin
      restart_frame();
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
  endtask

  // Queues one input beat and works out the mean it yields, if any.
  task automatic send_beat(logic op, logic [31:0] argb);
    pix_beat_t t;
    int w, h;
    t.op = op;
    {t.a, t.r, t.g, t.b} = argb;
    pixel_q.push_back(t);
    item_count++;
    w = eff_width();
    h = eff_height();
    if (op == bbe_pkg::OP_PIXEL) begin
      if (frame_done) return;
      win_store[(in_row * w + in_col) % bbe_pkg::LINE_DEPTH] = argb;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
        if (in_row >= h) begin
          in_row = 0;
          frame_done = 1'b1;
        end
      end
    end
    emit_mean();
  endtask

  task automatic write_reg(logic [bbe_pkg::CFG_IDX_W-1:0] idx, logic [DAT_W-1:0] value);
    @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    case (idx)
      bbe_pkg::REG_WIDTH:  cur_width  = value[10:0];
      bbe_pkg::REG_HEIGHT: cur_height = value;
      bbe_pkg::REG_RADIUS: cur_radius = value[2:0];
      default:             return;
    endcase
    restart_frame();
  endtask

  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (pixel_q.size() != 0 || pix.valid || blur_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_frame(int w, int h, int r);
    wait_idle();
    write_reg(bbe_pkg::REG_WIDTH, DAT_W'(w));
    write_reg(bbe_pkg::REG_HEIGHT, DAT_W'(h));
    write_reg(bbe_pkg::REG_RADIUS, DAT_W'(r));
    phase_count++;
  endtask

  // Drain beats until the frame's last mean has been predicted.
  task automatic flush_frame();
    while (frame_done) send_beat(bbe_pkg::OP_DRAIN, $urandom);
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0h, expected %0h (result %0d)", what, got, want,
             result_count);
    err_count++;
  endtask

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Driver: presents queued beats, holding each until it is accepted.
  int send_gap;
  always @(posedge clk) begin
    if (rst) begin
      pix.valid    <= 1'b0;
      pix.op       <= bbe_pkg::OP_PIXEL;
      pix.in_alpha <= 8'd0;
      pix.in_red   <= 8'd0;
      pix.in_green <= 8'd0;
      pix.in_blue  <= 8'd0;
      send_gap     <= 0;
    end else if (pix.valid && !pix.ready) begin
      // Beat still waiting; keep it on the bus.
    end else if (send_gap > 0) begin
      pix.valid <= 1'b0;
      send_gap  <= send_gap - 1;
    end else if (pixel_q.size() != 0) begin
      pix_beat_t t;
      t = pixel_q.pop_front();
      pix.op       <= t.op;
      pix.in_alpha <= t.a;
      pix.in_red   <= t.r;
      pix.in_green <= t.g;
      pix.in_blue  <= t.b;
      pix.valid    <= 1'b1;
      send_gap     <= pick_gap();
    end else begin
      pix.valid <= 1'b0;
    end
  end

  // Long result hold-off, counted down on its own.
  always @(posedge clk) begin
    if (rst) begin
      hold_ack  <= 0;
      hold_left <= 0;
    end else if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: stalls the result side at random and checks every beat.
  int recv_gap;
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
      recv_gap  <= 0;
    end else begin
      if (res.valid && res.ready) begin
        blur_beat_t e;
        if (blur_q.size() == 0) begin
          report_mismatch("unexpected result beat", 1, 0);
        end else begin
          e = blur_q.pop_front();
          if (res.blur_alpha !== e.a) report_mismatch("blur_alpha", res.blur_alpha, e.a);
          if (res.blur_red !== e.r) report_mismatch("blur_red", res.blur_red, e.r);
          if (res.blur_green !== e.g) report_mismatch("blur_green", res.blur_green, e.g);
          if (res.blur_blue !== e.b) report_mismatch("blur_blue", res.blur_blue, e.b);
          if (res.end_of_frame !== e.eof)
            report_mismatch("end_of_frame", res.end_of_frame, e.eof);
        end
        result_count++;
      end
      if (hold_req != hold_ack || hold_left > 0) begin
        res.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap  <= recv_gap - 1;
        res.ready <= 1'b0;
      end else if (pick_gap() != 0) begin
        recv_gap  <= pick_gap();
        res.ready <= 1'b0;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  initial begin
    int w, h, total, cut;
    cfg.valid = 1'b0;
    cfg.index = bbe_pkg::REG_WIDTH;
    cfg.data = '0;
    err_count = 0;
    item_count = 0;
    result_count = 0;
    phase_count = 0;
    no_idle = 1'b0;
    hold_req = 0;
    cur_width = 11'd1024;
    cur_height = 13'd1024;
    cur_radius = 3'd1;
    restart_frame();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: 3x2 frame, radius 0 acting as 1, unused index ignored.
    set_frame(3, 2, 0);
    write_reg(REG_UNUSED, '1);
    send_beat(bbe_pkg::OP_DRAIN, 32'h0);
    send_beat(bbe_pkg::OP_PIXEL, 32'h00000000);
    send_beat(bbe_pkg::OP_PIXEL, 32'hFFFFFFFF);
    send_beat(bbe_pkg::OP_DRAIN, 32'hFFFFFFFF);
    send_beat(bbe_pkg::OP_PIXEL, 32'hFF00FF00);
    send_beat(bbe_pkg::OP_PIXEL, 32'h00FF00FF);
    send_beat(bbe_pkg::OP_PIXEL, 32'hFFFFFFFF);
    send_beat(bbe_pkg::OP_PIXEL, 32'h01020304);
    send_beat(bbe_pkg::OP_PIXEL, 32'hFFFFFFFF);
    flush_frame();
    send_beat(bbe_pkg::OP_DRAIN, 32'h0);

    // Directed: frame smaller than the lag, radius above the maximum.
    set_frame(2, 3, 7);
    for (int i = 0; i < 6; i++) send_beat(bbe_pkg::OP_PIXEL, 32'hFFFFFFFF);
    flush_frame();

    // Directed: zero width and height act as a single pixel.
    set_frame(0, 0, 3);
    send_beat(bbe_pkg::OP_PIXEL, 32'h80808080);
    send_beat(bbe_pkg::OP_PIXEL, 32'h7F7F7F7F);

    // Random frames, mostly complete, some abandoned part way.
    cut = item_count + RANDOM_ITEMS;
    while (item_count < cut) begin
      w = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
      h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
      set_frame(w, h, $urandom_range(0, 7));
      no_idle = ($urandom_range(0, 4) == 0);
      total = eff_width() * eff_height();
      if ($urandom_range(0, 4) == 0) total = $urandom_range(0, total - 1);
      for (int i = 0; i < total; i++) begin
        if ($urandom_range(0, 9) == 0) send_beat(bbe_pkg::OP_DRAIN, $urandom);
        send_beat(bbe_pkg::OP_PIXEL, $urandom);
      end
      if (frame_done) begin
        repeat ($urandom_range(0, 2)) send_beat(bbe_pkg::OP_PIXEL, $urandom);
        flush_frame();
      end
    end
    no_idle = 1'b0;

    // Wider frame, largest radius: every mean but the first comes from a drain beat.
    set_frame(30, 2, 6);
    for (int i = 0; i < 60; i++) send_beat(bbe_pkg::OP_PIXEL, $urandom);
    flush_frame();

    // Height above the maximum, one column wide, with a long result hold-off.
    set_frame(1, 8191, 1);
    hold_req = 1;
    for (int i = 0; i < 100; i++) send_beat(bbe_pkg::OP_PIXEL, $urandom);

    wait_idle();
    $display("Ran %0d frame setups with %0d input beats and checked %0d blurred pixels.",
             phase_count, item_count, result_count);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("Timed out with %0d results outstanding.", blur_q.size());
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
